>>> hdl/scc_pkg.sv
// Shared constants and controller/datapath interface types for the coprime search.
`default_nettype none
package scc_pkg;

  localparam int VALUE_WIDTH = 32;

  typedef logic [VALUE_WIDTH-1:0] scc_value_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture operands, candidate = 2
    logic gcd_first;  // begin gcd of first operand and candidate
    logic gcd_second; // begin gcd of second operand and candidate
    logic gcd_step;   // one binary gcd step
    logic next_cand;  // advance candidate
    logic set_found;  // result = candidate
    logic set_none;   // result = -1
  } scc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic range_end;  // candidate reached the smaller operand, or operand negative
    logic gcd_done;   // gcd loop finished
    logic gcd_one;    // finished gcd equals one
  } scc_stat_t;

endpackage
`default_nettype wire

>>> hdl/smallest_common_coprime_search.sv
// Top level of the smallest common coprime search: controller plus datapath.
//
//  channel   signals                          handshake
//  request   start, first_value, second_value taken when start & !busy
//  result    done, coprime_found              done high for one cycle
//
//  A request with an empty search range goes from idle through the check state
//  to done; otherwise each candidate passes the check state and a binary gcd
//  with the first operand, then with the second if the first is one (up to
//  about 2*VALUE_WIDTH steps per gcd); the done state then gives the result.
//  The gcd subtract/shift unit sets the pace: one step per clock.
//  Synchronous reset returns the controller to idle; no request is in flight.
//  The receiver cannot stall: the done strobe is high for exactly one cycle.
`default_nettype none
module smallest_common_coprime_search
  import scc_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [VALUE_WIDTH-1:0] first_value,
  input  wire logic signed [VALUE_WIDTH-1:0] second_value,
  output logic                               done,
  output logic signed [VALUE_WIDTH-1:0]      coprime_found
);

  scc_cmd_t   cmd;
  scc_stat_t  stat;
  scc_value_t result;

  scc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  scc_datapath u_datapath (
    .clk          (clk),
    .first_value  (first_value),
    .second_value (second_value),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result)
  );

  assign coprime_found = $signed(result);

  // A taken request makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // Result strobe lasts one cycle and the block is idle right after
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe longer than one cycle");

  // A found candidate is at least two
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    (done && (result != '1)) |-> (result >= scc_value_t'(2)))
    else $error("found candidate below two");

  // Strobe only while busy
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe while idle");

endmodule
`default_nettype wire

>>> hdl/scc_datapath.sv
// Datapath: operand, candidate and binary gcd registers plus the result register.
`default_nettype none
module scc_datapath
  import scc_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic signed [VALUE_WIDTH-1:0] first_value,
  input  wire logic signed [VALUE_WIDTH-1:0] second_value,
  input  wire scc_cmd_t                      cmd,
  output scc_stat_t                          stat,
  output scc_value_t                         result
);

  scc_value_t op_a;
  scc_value_t op_b;
  scc_value_t cand;
  scc_value_t u;
  scc_value_t v;

  // Search range: empty for a negative operand, ends at the smaller operand
  assign stat.range_end = op_a[VALUE_WIDTH-1] | op_b[VALUE_WIDTH-1] |
                          (cand >= op_a) | (cand >= op_b);

  // Gcd ends when both values meet, or at once when both are even
  assign stat.gcd_done = (u == v) | (~u[0] & ~v[0]);
  assign stat.gcd_one  = (u == v) & (u == scc_value_t'(1));

  // Registers; one command per cycle at most
  always_ff @(posedge clk) begin
    priority if (cmd.load) begin
      op_a <= scc_value_t'($unsigned(first_value));
      op_b <= scc_value_t'($unsigned(second_value));
      cand <= scc_value_t'(2);
    end else if (cmd.gcd_first) begin
      u <= op_a;
      v <= cand;
    end else if (cmd.gcd_second) begin
      u <= op_b;
      v <= cand;
    end else if (cmd.gcd_step) begin
      // Stein step: at least one of u, v is odd here
      priority if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u > v) begin
        u <= u - v;
      end else begin
        v <= v - u;
      end
    end else if (cmd.next_cand) begin
      cand <= cand + scc_value_t'(1);
    end else if (cmd.set_found) begin
      result <= cand;
    end else if (cmd.set_none) begin
      result <= '1;
    end
  end

endmodule
`default_nettype wire

>>> hdl/scc_ctrl.sv
// Controller: sequences the candidate loop and the two gcd tests per candidate.
`default_nettype none
module scc_ctrl
  import scc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire scc_stat_t stat,
  output scc_cmd_t       cmd,
  output logic           busy,
  output logic           done
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_GCD_A = 3'd2;
  localparam logic [2:0] ST_GCD_B = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.range_end) begin
          cmd.set_none = 1'b1;
          state_next   = ST_DONE;
        end else begin
          cmd.gcd_first = 1'b1;
          state_next    = ST_GCD_A;
        end
      end
      ST_GCD_A: begin
        if (!stat.gcd_done) begin
          cmd.gcd_step = 1'b1;
        end else if (stat.gcd_one) begin
          cmd.gcd_second = 1'b1;
          state_next     = ST_GCD_B;
        end else begin
          cmd.next_cand = 1'b1;
          state_next    = ST_CHECK;
        end
      end
      ST_GCD_B: begin
        if (!stat.gcd_done) begin
          cmd.gcd_step = 1'b1;
        end else if (stat.gcd_one) begin
          cmd.set_found = 1'b1;
          state_next    = ST_DONE;
        end else begin
          cmd.next_cand = 1'b1;
          state_next    = ST_CHECK;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire
